### design/gtp_pkg.sv
// Shared types, constants and color tables for the glucose-to-palette color block.
package gtp_pkg;

  localparam int GlucoseW = 10;
  localparam int LevelW   = 3;
  localparam int IndexW   = 8;
  localparam int ColorW   = 8;
  localparam int RegIdxW  = 2;

  // Register indexes on the configuration channel
  localparam logic [RegIdxW-1:0] RegLowLimit   = 2'd0;
  localparam logic [RegIdxW-1:0] RegTarget     = 2'd1;
  localparam logic [RegIdxW-1:0] RegHighLimit  = 2'd2;
  localparam logic [RegIdxW-1:0] RegBrightness = 2'd3;

  localparam logic [GlucoseW-1:0] LowLimitRst   = 10'd90;
  localparam logic [GlucoseW-1:0] TargetRst     = 10'd110;
  localparam logic [GlucoseW-1:0] HighLimitRst  = 10'd200;
  localparam logic [LevelW-1:0]   BrightnessRst = 3'd0;

  // Fixed curve ends in mg/dl
  localparam logic [GlucoseW-1:0] VeryLowMgdl  = 10'd35;
  localparam logic [GlucoseW-1:0] VeryHighMgdl = 10'd300;

  // Anchor indexes of the palette
  localparam logic [IndexW-1:0] IdxMagenta = 8'd0;
  localparam logic [IndexW-1:0] IdxBlue    = 8'd52;
  localparam logic [IndexW-1:0] IdxGreen   = 8'd105;
  localparam logic [IndexW-1:0] IdxYellow  = 8'd146;
  localparam logic [IndexW-1:0] IdxRed     = 8'd187;

  localparam int PaletteLen = 188;

  typedef struct packed {
    logic [GlucoseW-1:0] glucose;
  } sample_word_t;

  typedef struct packed {
    logic [IndexW-1:0] palette_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] led_scale;
  } result_word_t;

  typedef struct packed {
    logic [RegIdxW-1:0]  index;
    logic [GlucoseW-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  function automatic logic [ColorW-1:0] led_scale_of(input logic [LevelW-1:0] level);
    logic [ColorW-1:0] s;
    case (level)
      3'd0:    s = 8'd255;
      3'd1:    s = 8'd128;
      3'd2:    s = 8'd64;
      3'd3:    s = 8'd32;
      3'd4:    s = 8'd16;
      3'd5:    s = 8'd4;
      default: s = 8'd0;   // levels six and seven switch the strip off
    endcase
    return s;
  endfunction

  localparam rgb_t Palette [PaletteLen] = '{
    '{8'd84,8'd0,8'd159}, '{8'd84,8'd0,8'd163}, '{8'd84,8'd0,8'd168}, '{8'd79,8'd0,8'd177},
    '{8'd78,8'd0,8'd182}, '{8'd77,8'd0,8'd186}, '{8'd76,8'd0,8'd191}, '{8'd70,8'd0,8'd200},
    '{8'd68,8'd0,8'd204}, '{8'd66,8'd0,8'd209}, '{8'd60,8'd0,8'd214}, '{8'd58,8'd0,8'd218},
    '{8'd55,8'd0,8'd223}, '{8'd46,8'd0,8'd232}, '{8'd43,8'd0,8'd236}, '{8'd40,8'd0,8'd241},
    '{8'd36,8'd0,8'd245}, '{8'd33,8'd0,8'd250}, '{8'd25,8'd0,8'd255}, '{8'd16,8'd0,8'd255},
    '{8'd12,8'd0,8'd255}, '{8'd4,8'd0,8'd255}, '{8'd0,8'd0,8'd255}, '{8'd0,8'd4,8'd255},
    '{8'd0,8'd16,8'd255}, '{8'd0,8'd21,8'd255}, '{8'd0,8'd25,8'd255}, '{8'd0,8'd29,8'd255},
    '{8'd0,8'd38,8'd255}, '{8'd0,8'd42,8'd255}, '{8'd0,8'd46,8'd255}, '{8'd0,8'd51,8'd255},
    '{8'd0,8'd63,8'd255}, '{8'd0,8'd67,8'd255}, '{8'd0,8'd72,8'd255}, '{8'd0,8'd84,8'd255},
    '{8'd0,8'd89,8'd255}, '{8'd0,8'd93,8'd255}, '{8'd0,8'd97,8'd255}, '{8'd0,8'd106,8'd255},
    '{8'd0,8'd110,8'd255}, '{8'd0,8'd114,8'd255}, '{8'd0,8'd119,8'd255}, '{8'd0,8'd127,8'd255},
    '{8'd0,8'd135,8'd255}, '{8'd0,8'd140,8'd255}, '{8'd0,8'd152,8'd255}, '{8'd0,8'd157,8'd255},
    '{8'd0,8'd161,8'd255}, '{8'd0,8'd165,8'd255}, '{8'd0,8'd174,8'd255}, '{8'd0,8'd178,8'd255},
    '{8'd0,8'd182,8'd255}, '{8'd0,8'd187,8'd255}, '{8'd0,8'd195,8'd255}, '{8'd0,8'd199,8'd255},
    '{8'd0,8'd216,8'd255}, '{8'd0,8'd220,8'd255}, '{8'd0,8'd225,8'd255}, '{8'd0,8'd229,8'd255},
    '{8'd0,8'd233,8'd255}, '{8'd0,8'd242,8'd255}, '{8'd0,8'd246,8'd255}, '{8'd0,8'd250,8'd255},
    '{8'd0,8'd255,8'd255}, '{8'd0,8'd255,8'd246}, '{8'd0,8'd255,8'd242}, '{8'd0,8'd255,8'd238},
    '{8'd0,8'd255,8'd225}, '{8'd0,8'd255,8'd216}, '{8'd0,8'd255,8'd212}, '{8'd0,8'd255,8'd203},
    '{8'd0,8'd255,8'd199}, '{8'd0,8'd255,8'd195}, '{8'd0,8'd255,8'd191}, '{8'd0,8'd255,8'd187},
    '{8'd0,8'd255,8'd178}, '{8'd0,8'd255,8'd174}, '{8'd0,8'd255,8'd170}, '{8'd0,8'd255,8'd157},
    '{8'd0,8'd255,8'd152}, '{8'd0,8'd255,8'd144}, '{8'd0,8'd255,8'd135}, '{8'd0,8'd255,8'd131},
    '{8'd0,8'd255,8'd127}, '{8'd0,8'd255,8'd123}, '{8'd0,8'd255,8'd114}, '{8'd0,8'd255,8'd110},
    '{8'd0,8'd255,8'd106}, '{8'd0,8'd255,8'd102}, '{8'd0,8'd255,8'd89}, '{8'd0,8'd255,8'd84},
    '{8'd0,8'd255,8'd80}, '{8'd0,8'd255,8'd76}, '{8'd0,8'd255,8'd63}, '{8'd0,8'd255,8'd59},
    '{8'd0,8'd255,8'd55}, '{8'd0,8'd255,8'd46}, '{8'd0,8'd255,8'd42}, '{8'd0,8'd255,8'd38},
    '{8'd0,8'd255,8'd25}, '{8'd0,8'd255,8'd21}, '{8'd0,8'd255,8'd16}, '{8'd0,8'd255,8'd12},
    '{8'd0,8'd255,8'd8}, '{8'd0,8'd255,8'd0}, '{8'd8,8'd255,8'd0}, '{8'd12,8'd255,8'd0},
    '{8'd21,8'd255,8'd0}, '{8'd25,8'd255,8'd0}, '{8'd29,8'd255,8'd0}, '{8'd42,8'd255,8'd0},
    '{8'd46,8'd255,8'd0}, '{8'd51,8'd255,8'd0}, '{8'd55,8'd255,8'd0}, '{8'd63,8'd255,8'd0},
    '{8'd67,8'd255,8'd0}, '{8'd72,8'd255,8'd0}, '{8'd76,8'd255,8'd0}, '{8'd89,8'd255,8'd0},
    '{8'd93,8'd255,8'd0}, '{8'd97,8'd255,8'd0}, '{8'd110,8'd255,8'd0}, '{8'd114,8'd255,8'd0},
    '{8'd119,8'd255,8'd0}, '{8'd123,8'd255,8'd0}, '{8'd131,8'd255,8'd0}, '{8'd135,8'd255,8'd0},
    '{8'd140,8'd255,8'd0}, '{8'd144,8'd255,8'd0}, '{8'd153,8'd255,8'd0}, '{8'd161,8'd255,8'd0},
    '{8'd165,8'd255,8'd0}, '{8'd178,8'd255,8'd0}, '{8'd182,8'd255,8'd0}, '{8'd187,8'd255,8'd0},
    '{8'd191,8'd255,8'd0}, '{8'd199,8'd255,8'd0}, '{8'd203,8'd255,8'd0}, '{8'd208,8'd255,8'd0},
    '{8'd212,8'd255,8'd0}, '{8'd221,8'd255,8'd0}, '{8'd225,8'd255,8'd0}, '{8'd242,8'd255,8'd0},
    '{8'd246,8'd255,8'd0}, '{8'd250,8'd255,8'd0}, '{8'd255,8'd255,8'd0}, '{8'd255,8'd250,8'd0},
    '{8'd255,8'd242,8'd0}, '{8'd255,8'd238,8'd0}, '{8'd255,8'd233,8'd0}, '{8'd255,8'd229,8'd0},
    '{8'd255,8'd221,8'd0}, '{8'd255,8'd216,8'd0}, '{8'd255,8'd212,8'd0}, '{8'd255,8'd199,8'd0},
    '{8'd255,8'd191,8'd0}, '{8'd255,8'd187,8'd0}, '{8'd255,8'd178,8'd0}, '{8'd255,8'd174,8'd0},
    '{8'd255,8'd170,8'd0}, '{8'd255,8'd165,8'd0}, '{8'd255,8'd161,8'd0}, '{8'd255,8'd153,8'd0},
    '{8'd255,8'd148,8'd0}, '{8'd255,8'd144,8'd0}, '{8'd255,8'd131,8'd0}, '{8'd255,8'd127,8'd0},
    '{8'd255,8'd119,8'd0}, '{8'd255,8'd110,8'd0}, '{8'd255,8'd106,8'd0}, '{8'd255,8'd102,8'd0},
    '{8'd255,8'd97,8'd0}, '{8'd255,8'd89,8'd0}, '{8'd255,8'd85,8'd0}, '{8'd255,8'd80,8'd0},
    '{8'd255,8'd76,8'd0}, '{8'd255,8'd63,8'd0}, '{8'd255,8'd59,8'd0}, '{8'd255,8'd55,8'd0},
    '{8'd255,8'd51,8'd0}, '{8'd255,8'd38,8'd0}, '{8'd255,8'd34,8'd0}, '{8'd255,8'd29,8'd0},
    '{8'd255,8'd21,8'd0}, '{8'd255,8'd17,8'd0}, '{8'd255,8'd12,8'd0}, '{8'd255,8'd0,8'd0}
  };

endpackage

### design/gtp_stream_if.sv
// Valid/ready channel carrying one word of a given type.
interface gtp_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/glucose_to_palette_color.sv
// Glucose sample to palette color: segment select, multiply, divide, palette lookup.
//
// Channels:
//   sample : sink of glucose words (mg/dl, 10 bits).
//   result : source of result words: palette index, red, green, blue, led_scale.
//   cfg    : register writes (index, value); ready except in reset. Index 0 low_limit,
//            1 target_level, 2 high_limit, 3 brightness_level (low 3 bits used).
//            Write registers only while no word is in flight.
// Pipeline: six register stages -- segment select, multiply, three radix-4
//   restoring divide stages (two quotient bits each), then index add and
//   palette lookup into the output register.
// A sample passes stage A, stage B, the divide stages and the output register.
// Throughput: one word per cycle unless stalled; divide stages set depth, not rate.
// Stall: the whole pipe holds while result.valid is high and result.ready low;
//   sample.ready drops in that cycle, so no word is lost or repeated.
// Reset (rst, synchronous, active high): all stage valid bits clear and the
//   registers return to 90 / 110 / 200 / level 0; sample.ready and cfg.ready
//   stay low while rst is high.
module glucose_to_palette_color (
  input  logic clk,
  input  logic rst,
  gtp_stream_if.sink   sample,
  gtp_stream_if.source result,
  gtp_stream_if.sink   cfg
);

  localparam int NumW   = 16;  // (g - start) * span, span <= 53
  localparam int SpanW  = 6;
  localparam int QuotW  = 6;   // quotient never exceeds the span
  localparam int DivStg = 3;

  typedef struct packed {
    logic [NumW-1:0]               rem;
    logic [QuotW-1:0]              quot;
    logic [gtp_pkg::GlucoseW-1:0]  width;
    logic [gtp_pkg::IndexW-1:0]    base;
    logic [gtp_pkg::ColorW-1:0]    scale;
  } div_stage_t;

  // ---------------- configuration registers ----------------
  logic [gtp_pkg::GlucoseW-1:0] low_limit;
  logic [gtp_pkg::GlucoseW-1:0] target_level;
  logic [gtp_pkg::GlucoseW-1:0] high_limit;
  logic [gtp_pkg::LevelW-1:0]   brightness_level;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit        <= gtp_pkg::LowLimitRst;
      target_level     <= gtp_pkg::TargetRst;
      high_limit       <= gtp_pkg::HighLimitRst;
      brightness_level <= gtp_pkg::BrightnessRst;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        gtp_pkg::RegLowLimit:   low_limit        <= cfg.data.value;
        gtp_pkg::RegTarget:     target_level     <= cfg.data.value;
        gtp_pkg::RegHighLimit:  high_limit       <= cfg.data.value;
        gtp_pkg::RegBrightness: brightness_level <= cfg.data.value[gtp_pkg::LevelW-1:0];
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // One enable for the whole pipe; the output register is the last stage.
  logic adv;
  logic a_vld, b_vld, out_vld;
  logic [DivStg-1:0] d_vld;

  assign adv          = !out_vld || result.ready;
  assign sample.ready = adv && !rst;
  assign result.valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      d_vld   <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      a_vld   <= sample.valid;
      b_vld   <= a_vld;
      d_vld   <= {d_vld[DivStg-2:0], b_vld};
      out_vld <= d_vld[DivStg-1];
    end
  end

  // ---------------- stage A: segment select ----------------
  // First segment whose end is not below the sample; ends outside the curve
  // become a zero numerator so the base index passes straight through.
  logic [gtp_pkg::GlucoseW-1:0] g;
  logic [gtp_pkg::GlucoseW-1:0] seg_start, seg_end;
  logic [SpanW-1:0]             seg_span;
  logic [gtp_pkg::IndexW-1:0]   seg_base;
  logic                         seg_flat;

  assign g = sample.data.glucose;

  always_comb begin
    seg_start = gtp_pkg::VeryLowMgdl;
    seg_end   = gtp_pkg::VeryHighMgdl;
    seg_span  = '0;
    seg_base  = gtp_pkg::IdxMagenta;
    seg_flat  = 1'b0;
    if (g <= gtp_pkg::VeryLowMgdl) begin
      seg_flat = 1'b1;
    end else if (g <= low_limit) begin
      seg_end  = low_limit;
      seg_span = SpanW'(gtp_pkg::IdxBlue - gtp_pkg::IdxMagenta);
    end else if (g <= target_level) begin
      seg_start = low_limit;
      seg_end   = target_level;
      seg_span  = SpanW'(gtp_pkg::IdxGreen - gtp_pkg::IdxBlue);
      seg_base  = gtp_pkg::IdxBlue;
    end else if (g <= high_limit) begin
      seg_start = target_level;
      seg_end   = high_limit;
      seg_span  = SpanW'(gtp_pkg::IdxYellow - gtp_pkg::IdxGreen);
      seg_base  = gtp_pkg::IdxGreen;
    end else if (g <= gtp_pkg::VeryHighMgdl) begin
      seg_start = high_limit;
      seg_span  = SpanW'(gtp_pkg::IdxRed - gtp_pkg::IdxYellow);
      seg_base  = gtp_pkg::IdxYellow;
    end else begin
      seg_flat = 1'b1;
      seg_base = gtp_pkg::IdxRed;
    end
  end

  logic [gtp_pkg::GlucoseW-1:0] a_diff, a_width;
  logic [SpanW-1:0]             a_span;
  logic [gtp_pkg::IndexW-1:0]   a_base;
  logic [gtp_pkg::ColorW-1:0]   a_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff  <= seg_flat ? '0 : g - seg_start;
      a_width <= seg_flat ? gtp_pkg::GlucoseW'(1) : seg_end - seg_start;
      a_span  <= seg_span;
      a_base  <= seg_base;
      a_scale <= gtp_pkg::led_scale_of(brightness_level);
    end
  end

  // ---------------- stage B: multiply ----------------
  logic [NumW-1:0]              b_num;
  logic [gtp_pkg::GlucoseW-1:0] b_width;
  logic [gtp_pkg::IndexW-1:0]   b_base;
  logic [gtp_pkg::ColorW-1:0]   b_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_num   <= NumW'(a_diff) * NumW'(a_span);
      b_width <= a_width;
      b_base  <= a_base;
      b_scale <= a_scale;
    end
  end

  // ---------------- divide stages ----------------
  // Restoring division, two quotient bits per stage, MSB first.
  function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                             input logic [gtp_pkg::GlucoseW-1:0] width,
                                             input logic [2:0] sh);
    logic [NumW-1:0] dsh;
    dsh = NumW'(width) << sh;
    if (rem >= dsh) return {1'b1, rem - dsh};
    else            return {1'b0, rem};
  endfunction

  div_stage_t d_src [DivStg];
  div_stage_t d_nxt [DivStg];
  div_stage_t d_reg [DivStg];

  assign d_src[0] = '{rem: b_num, quot: '0, width: b_width, base: b_base, scale: b_scale};

  for (genvar k = 0; k < DivStg; k++) begin : g_div
    if (k > 0) begin : g_link
      assign d_src[k] = d_reg[k-1];
    end

    logic [NumW:0] s_hi, s_lo;

    always_comb begin
      s_hi = div_step(d_src[k].rem, d_src[k].width, 3'(QuotW - 1 - 2 * k));
      s_lo = div_step(s_hi[NumW-1:0], d_src[k].width, 3'(QuotW - 2 - 2 * k));
      d_nxt[k]      = d_src[k];
      d_nxt[k].rem  = s_lo[NumW-1:0];
      d_nxt[k].quot = {d_src[k].quot[QuotW-3:0], s_hi[NumW], s_lo[NumW]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_reg[k] <= d_nxt[k];
      end
    end
  end

  // ---------------- output stage: index and palette lookup ----------------
  logic [gtp_pkg::IndexW-1:0] idx_next;
  gtp_pkg::rgb_t              color_next;
  gtp_pkg::result_word_t      out_word;

  assign idx_next   = d_reg[DivStg-1].base + gtp_pkg::IndexW'(d_reg[DivStg-1].quot);
  assign color_next = gtp_pkg::Palette[idx_next];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.palette_index <= idx_next;
      out_word.red           <= color_next.red;
      out_word.green         <= color_next.green;
      out_word.blue          <= color_next.blue;
      out_word.led_scale     <= d_reg[DivStg-1].scale;
    end
  end

  assign result.data = out_word;

  // ---------------- assertions ----------------
  // Division must end with a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    d_vld[DivStg-1] |-> (d_reg[DivStg-1].rem < NumW'(d_reg[DivStg-1].width)))
    else $error("divide stage left remainder not below segment width");

  // Index never leaves the palette.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_word.palette_index <= gtp_pkg::IdxRed))
    else $error("palette index beyond last entry");

  // A stalled pipe keeps the occupancy of stages A, B and the divide stages.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(a_vld) && $stable(b_vld) && $stable(d_vld)))
    else $error("stage valid bits moved during a stall");

endmodule

### sim/tb_glucose_to_palette_color.sv
// Testbench for glucose_to_palette_color: random samples and settings checked against a predictor.
module tb_glucose_to_palette_color;

  // Curve ends and anchor indexes, kept independent of the design package
  localparam int unsigned LowEndMgdl    = 35;
  localparam int unsigned HighEndMgdl   = 300;
  localparam int unsigned AnchorMagenta = 0;
  localparam int unsigned AnchorBlue    = 52;
  localparam int unsigned AnchorGreen   = 105;
  localparam int unsigned AnchorYellow  = 146;
  localparam int unsigned AnchorRed     = 187;
  localparam int unsigned ColorCount    = 188;

  // Pipe is 6 deep; idle this long after the last word before a register write
  localparam int DrainCycles  = 12;
  localparam int RandPhases   = 18;
  localparam int WordsPerPhase = 105;

  // Red, green, blue per palette entry, three values per index
  localparam int unsigned PalTab [3*ColorCount] = '{
    84,0,159, 84,0,163, 84,0,168, 79,0,177, 78,0,182, 77,0,186, 76,0,191, 70,0,200,
    68,0,204, 66,0,209, 60,0,214, 58,0,218, 55,0,223, 46,0,232, 43,0,236, 40,0,241,
    36,0,245, 33,0,250, 25,0,255, 16,0,255, 12,0,255, 4,0,255, 0,0,255, 0,4,255,
    0,16,255, 0,21,255, 0,25,255, 0,29,255, 0,38,255, 0,42,255, 0,46,255, 0,51,255,
    0,63,255, 0,67,255, 0,72,255, 0,84,255, 0,89,255, 0,93,255, 0,97,255, 0,106,255,
    0,110,255, 0,114,255, 0,119,255, 0,127,255, 0,135,255, 0,140,255, 0,152,255, 0,157,255,
    0,161,255, 0,165,255, 0,174,255, 0,178,255, 0,182,255, 0,187,255, 0,195,255, 0,199,255,
    0,216,255, 0,220,255, 0,225,255, 0,229,255, 0,233,255, 0,242,255, 0,246,255, 0,250,255,
    0,255,255, 0,255,246, 0,255,242, 0,255,238, 0,255,225, 0,255,216, 0,255,212, 0,255,203,
    0,255,199, 0,255,195, 0,255,191, 0,255,187, 0,255,178, 0,255,174, 0,255,170, 0,255,157,
    0,255,152, 0,255,144, 0,255,135, 0,255,131, 0,255,127, 0,255,123, 0,255,114, 0,255,110,
    0,255,106, 0,255,102, 0,255,89, 0,255,84, 0,255,80, 0,255,76, 0,255,63, 0,255,59,
    0,255,55, 0,255,46, 0,255,42, 0,255,38, 0,255,25, 0,255,21, 0,255,16, 0,255,12,
    0,255,8, 0,255,0, 8,255,0, 12,255,0, 21,255,0, 25,255,0, 29,255,0, 42,255,0,
    46,255,0, 51,255,0, 55,255,0, 63,255,0, 67,255,0, 72,255,0, 76,255,0, 89,255,0,
    93,255,0, 97,255,0, 110,255,0, 114,255,0, 119,255,0, 123,255,0, 131,255,0, 135,255,0,
    140,255,0, 144,255,0, 153,255,0, 161,255,0, 165,255,0, 178,255,0, 182,255,0, 187,255,0,
    191,255,0, 199,255,0, 203,255,0, 208,255,0, 212,255,0, 221,255,0, 225,255,0, 242,255,0,
    246,255,0, 250,255,0, 255,255,0, 255,250,0, 255,242,0, 255,238,0, 255,233,0, 255,229,0,
    255,221,0, 255,216,0, 255,212,0, 255,199,0, 255,191,0, 255,187,0, 255,178,0, 255,174,0,
    255,170,0, 255,165,0, 255,161,0, 255,153,0, 255,148,0, 255,144,0, 255,131,0, 255,127,0,
    255,119,0, 255,110,0, 255,106,0, 255,102,0, 255,97,0, 255,89,0, 255,85,0, 255,80,0,
    255,76,0, 255,63,0, 255,59,0, 255,55,0, 255,51,0, 255,38,0, 255,34,0, 255,29,0,
    255,21,0, 255,17,0, 255,12,0, 255,0,0
  };

  // Levels six and seven turn the strip off
  localparam int unsigned ScaleTab [8] = '{255, 128, 64, 32, 16, 4, 0, 0};

  // Scoreboard: shadow registers, predicted colors in acceptance order, error count
  class color_tracker;
    bit [gtp_pkg::GlucoseW-1:0] low_lim;
    bit [gtp_pkg::GlucoseW-1:0] target;
    bit [gtp_pkg::GlucoseW-1:0] high_lim;
    bit [gtp_pkg::LevelW-1:0]   level;
    gtp_pkg::result_word_t      pending_colors [$];
    int                         errors;

    function new();
      low_lim  = 10'd90;
      target   = 10'd110;
      high_lim = 10'd200;
      level    = 3'd0;
      errors   = 0;
    endfunction

    function void set_reg(logic [gtp_pkg::RegIdxW-1:0] idx,
                          logic [gtp_pkg::GlucoseW-1:0] value);
      case (idx)
        gtp_pkg::RegLowLimit:   low_lim  = value;
        gtp_pkg::RegTarget:     target   = value;
        gtp_pkg::RegHighLimit:  high_lim = value;
        gtp_pkg::RegBrightness: level    = value[gtp_pkg::LevelW-1:0];
        default: ;
      endcase
    endfunction

    // Linear step within one segment; caller ensures s < g <= e
    function int unsigned interp(int unsigned g, int unsigned s, int unsigned e,
                                 int unsigned lo, int unsigned hi);
      if (e == s) return lo;
      return (g - s) * (hi - lo) / (e - s) + lo;
    endfunction

    // Segments are tried in order low, target, high, top end; first end >= g wins
    function gtp_pkg::result_word_t map_glucose(bit [gtp_pkg::GlucoseW-1:0] g);
      int unsigned gi;
      int unsigned idx;
      gtp_pkg::result_word_t w;
      gi = g;
      if (gi <= LowEndMgdl)
        idx = AnchorMagenta;
      else if (gi <= low_lim)
        idx = interp(gi, LowEndMgdl, low_lim, AnchorMagenta, AnchorBlue);
      else if (gi <= target)
        idx = interp(gi, low_lim, target, AnchorBlue, AnchorGreen);
      else if (gi <= high_lim)
        idx = interp(gi, target, high_lim, AnchorGreen, AnchorYellow);
      else if (gi <= HighEndMgdl)
        idx = interp(gi, high_lim, HighEndMgdl, AnchorYellow, AnchorRed);
      else
        idx = AnchorRed;
      if (idx >= ColorCount) idx = AnchorRed;
      w.palette_index = idx[gtp_pkg::IndexW-1:0];
      w.red       = PalTab[3*idx][gtp_pkg::ColorW-1:0];
      w.green     = PalTab[3*idx+1][gtp_pkg::ColorW-1:0];
      w.blue      = PalTab[3*idx+2][gtp_pkg::ColorW-1:0];
      w.led_scale = ScaleTab[level][gtp_pkg::ColorW-1:0];
      return w;
    endfunction

    function void note_sample(bit [gtp_pkg::GlucoseW-1:0] g);
      pending_colors.push_back(map_glucose(g));
    endfunction

    task report(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(gtp_pkg::result_word_t got);
      gtp_pkg::result_word_t want;
      if (pending_colors.size() == 0) begin
        report("word with nothing pending, index", got.palette_index, -1);
        return;
      end
      want = pending_colors.pop_front();
      if (got.palette_index !== want.palette_index)
        report("palette_index", got.palette_index, want.palette_index);
      if (got.red !== want.red) report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue) report("blue", got.blue, want.blue);
      if (got.led_scale !== want.led_scale)
        report("led_scale", got.led_scale, want.led_scale);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  gtp_stream_if #(.word_t(gtp_pkg::sample_word_t)) sample_ch ();
  gtp_stream_if #(.word_t(gtp_pkg::result_word_t)) result_ch ();
  gtp_stream_if #(.word_t(gtp_pkg::cfg_word_t))    cfg_ch ();

  glucose_to_palette_color DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  color_tracker tracker;

  // Per-phase idle ceilings; zero gives a stretch at full rate on that side
  int in_gap_max;
  int out_stall_max;

  always #10 clk = ~clk;

  // Send one sample word: optional idle gap, then hold valid until taken.
  // Valid stays high across back-to-back words so it is never dropped and
  // raised in the same step.
  task send_sample(input logic [gtp_pkg::GlucoseW-1:0] g);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.data.glucose <= g;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    tracker.note_sample(g);
  endtask

  task write_reg(input logic [gtp_pkg::RegIdxW-1:0] idx,
                 input logic [gtp_pkg::GlucoseW-1:0] value);
    gtp_pkg::cfg_word_t w;
    w.index = idx;
    w.value = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_reg(idx, value);
  endtask

  task program_regs(input logic [gtp_pkg::GlucoseW-1:0] lo,
                    input logic [gtp_pkg::GlucoseW-1:0] tg,
                    input logic [gtp_pkg::GlucoseW-1:0] hi,
                    input logic [gtp_pkg::GlucoseW-1:0] lvl);
    write_reg(gtp_pkg::RegLowLimit, lo);
    write_reg(gtp_pkg::RegTarget, tg);
    write_reg(gtp_pkg::RegHighLimit, hi);
    write_reg(gtp_pkg::RegBrightness, lvl);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers may only change with the pipe empty
  task wait_idle();
    while (tracker.pending_colors.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly the active 0..340 band, some hits right around a segment edge,
  // the rest anywhere in the 10-bit range.
  function automatic logic [gtp_pkg::GlucoseW-1:0] pick_glucose();
    int sel;
    int edge_pt;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return gtp_pkg::GlucoseW'($urandom_range(0, 340));
    if (sel <= 7) begin
      case ($urandom_range(0, 4))
        0: edge_pt = LowEndMgdl;
        1: edge_pt = tracker.low_lim;
        2: edge_pt = tracker.target;
        3: edge_pt = tracker.high_lim;
        default: edge_pt = HighEndMgdl;
      endcase
      edge_pt = edge_pt + $urandom_range(0, 4) - 2;
      if (edge_pt < 0) edge_pt = 0;
      if (edge_pt > 1023) edge_pt = 1023;
      return gtp_pkg::GlucoseW'(edge_pt);
    end
    return gtp_pkg::GlucoseW'($urandom_range(0, 1023));
  endfunction

  // Result side: random back-pressure per word
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_result(result_ch.data);
  end

  initial begin
    logic [gtp_pkg::GlucoseW-1:0] directed [$];
    logic [gtp_pkg::GlucoseW-1:0] lo, tg, hi, tmp, lvl_word;
    int mode;
    tracker = new();
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    in_gap_max      = 5;
    out_stall_max   = 5;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings: floor, each segment edge and its
    // neighbors, the top end, saturation and alternating bit patterns.
    directed = '{10'd0, 10'd35, 10'd36, 10'd62, 10'd89, 10'd90, 10'd91, 10'd109,
                 10'd110, 10'd111, 10'd155, 10'd199, 10'd200, 10'd201, 10'd299,
                 10'd300, 10'd301, 10'd1023, 10'd682, 10'd341, 10'd512};
    foreach (directed[i]) send_sample(directed[i]);
    sample_ch.valid <= 1'b0;

    for (int p = 0; p < RandPhases; p++) begin
      // First phases pin the corners: all segments empty, all beyond the top
      // end, thresholds sitting on the top end, reversed order, upper range
      // limit and the narrowest ordered widths; then random settings.
      case (p)
        0: begin lo = 10'd0;    tg = 10'd0;    hi = 10'd0;    lvl_word = 10'd5; end
        1: begin lo = 10'd1023; tg = 10'd1023; hi = 10'd1023; lvl_word = 10'd7; end
        2: begin lo = 10'd300;  tg = 10'd300;  hi = 10'd300;  lvl_word = 10'd6; end
        3: begin lo = 10'd200;  tg = 10'd110;  hi = 10'd90;   lvl_word = 10'd1; end
        4: begin lo = 10'd999;  tg = 10'd999;  hi = 10'd999;  lvl_word = 10'd4; end
        5: begin lo = 10'd36;   tg = 10'd37;   hi = 10'd38;   lvl_word = 10'd1018; end
        default: begin
          mode = $urandom_range(0, 3);
          if (mode <= 1) begin
            lo = gtp_pkg::GlucoseW'($urandom_range(35, 300));
            tg = gtp_pkg::GlucoseW'($urandom_range(35, 300));
            hi = gtp_pkg::GlucoseW'($urandom_range(35, 300));
            if (lo > tg) begin tmp = lo; lo = tg; tg = tmp; end
            if (tg > hi) begin tmp = tg; tg = hi; hi = tmp; end
            if (lo > tg) begin tmp = lo; lo = tg; tg = tmp; end
          end else if (mode == 2) begin
            lo = gtp_pkg::GlucoseW'($urandom_range(0, 999));
            tg = gtp_pkg::GlucoseW'($urandom_range(0, 999));
            hi = gtp_pkg::GlucoseW'($urandom_range(0, 999));
          end else begin
            lo = gtp_pkg::GlucoseW'($urandom);
            tg = gtp_pkg::GlucoseW'($urandom);
            hi = gtp_pkg::GlucoseW'($urandom);
          end
          lvl_word = gtp_pkg::GlucoseW'(($urandom_range(0, 3) == 0)
                                        ? $urandom_range(6, 7)
                                        : $urandom_range(0, 5));
          // only the low three bits count; junk above them now and then
          if ($urandom_range(0, 3) == 0)
            lvl_word[gtp_pkg::GlucoseW-1:gtp_pkg::LevelW] =
              (gtp_pkg::GlucoseW - gtp_pkg::LevelW)'($urandom);
        end
      endcase

      wait_idle();
      program_regs(lo, tg, hi, lvl_word);
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 5;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      for (int n = 0; n < WordsPerPhase; n++) send_sample(pick_glucose());
      sample_ch.valid <= 1'b0;
    end

    while (tracker.pending_colors.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: slowest legal run is well under a tenth of this
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
